/* rtl/v3a_pkg.sv */
// Shared types, constants and helper functions for the three-component vector ALU.
package v3a_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_W      = 2 * DATA_WIDTH;
    localparam int WIDE_W      = 2 * DATA_WIDTH + 2;
    localparam int LEN_W       = DATA_WIDTH;
    localparam int QUO_W       = FRAC_BITS + 1;
    localparam int NRM_W       = FRAC_BITS + 2;
    // A dot product with a unit vector stays below the length of a, about 2^32.
    localparam int DOT_W       = DATA_WIDTH + 2;
    localparam int PRJ_W       = NRM_W + DOT_W;
    localparam int SQRT_STAGES = DATA_WIDTH;
    localparam int DIV_STAGES  = QUO_W;
    // Input register, squares, sum, root, divider prep, quotient steps, sign, four ALU stages.
    localparam int LATENCY     = 3 + SQRT_STAGES + 1 + DIV_STAGES + 1 + 4;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef t_data [2:0] t_vec3;

    typedef enum logic [2:0] {
        CMD_LEN   = 3'd0,
        CMD_SCALE = 3'd1,
        CMD_NORM  = 3'd2,
        CMD_ADD   = 3'd3,
        CMD_SUB   = 3'd4,
        CMD_DOT   = 3'd5,
        CMD_CROSS = 3'd6,
        CMD_PROJ  = 3'd7
    } t_cmd;

    typedef struct packed {
        t_cmd  cmd;
        t_data a_x;
        t_data a_y;
        t_data a_z;
        t_data b_x;
        t_data b_y;
        t_data b_z;
        t_data factor;
    } t_req;

    typedef struct packed {
        t_data res_x;
        t_data res_y;
        t_data res_z;
        t_data res_scalar;
        logic  overflow;
    } t_res;

    // Request together with the length and the normalized vector.
    typedef struct packed {
        t_req                        req;
        logic [LEN_W-1:0]            len;
        logic [2:0][NRM_W-1:0]       nb;
    } t_nrm;

    localparam t_data DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_data DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // The vector that length, normalize and projection work on.
    function automatic t_vec3 sel_vec(input t_req r);
        t_vec3 v;
        if (r.cmd == CMD_PROJ) begin
            v = {r.b_z, r.b_y, r.b_x};
        end else begin
            v = {r.a_z, r.a_y, r.a_x};
        end
        return v;
    endfunction

    // True when a wide value does not fit the result width.
    function automatic logic sat_ovf(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-DATA_WIDTH:0] top;
        top = v[WIDE_W-1:DATA_WIDTH-1];
        return !((&top) || (~|top));
    endfunction

    // Clamp a wide value to the signed result range.
    function automatic t_data sat_val(input logic signed [WIDE_W-1:0] v);
        t_data r;
        if (sat_ovf(v)) begin
            r = v[WIDE_W-1] ? DATA_MIN : DATA_MAX;
        end else begin
            r = v[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/v3a_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module v3a_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [v3a_pkg::PROD_W-1:0]  i_sum,
    input  v3a_pkg::t_req               i_req,
    output logic                        o_valid,
    output logic [v3a_pkg::LEN_W-1:0]   o_len,
    output v3a_pkg::t_req               o_req
);
    import v3a_pkg::*;

    logic              r_valid [SQRT_STAGES];
    t_req              r_req   [SQRT_STAGES];
    logic [PROD_W-1:0] r_rem   [SQRT_STAGES];
    logic [PROD_W-1:0] r_root  [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
        localparam int BIT_POS = PROD_W - 2 - 2 * k;

        logic              src_valid;
        t_req              src_req;
        logic [PROD_W-1:0] src_rem;
        logic [PROD_W-1:0] src_root;
        logic [PROD_W:0]   n_trial;

        if (k == 0) begin : g_first
            assign src_valid = i_valid;
            assign src_req   = i_req;
            assign src_rem   = i_sum;
            assign src_root  = '0;
        end else begin : g_next
            assign src_valid = r_valid[k-1];
            assign src_req   = r_req[k-1];
            assign src_rem   = r_rem[k-1];
            assign src_root  = r_root[k-1];
        end

        // Trial subtrahend for this result bit.
        assign n_trial = {1'b0, src_root} + ((PROD_W+1)'(1) << BIT_POS);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= src_valid;
            end
            r_req[k] <= src_req;
            if ({1'b0, src_rem} >= n_trial) begin
                r_rem[k]  <= src_rem - n_trial[PROD_W-1:0];
                r_root[k] <= (src_root >> 1) + (PROD_W'(1) << BIT_POS);
            end else begin
                r_rem[k]  <= src_rem;
                r_root[k] <= src_root >> 1;
            end
        end
    end

    assign o_valid = r_valid[SQRT_STAGES-1];
    assign o_req   = r_req[SQRT_STAGES-1];
    assign o_len   = r_root[SQRT_STAGES-1][LEN_W-1:0];

endmodule

/* rtl/v3a_div.sv */
// Pipelined normalizer: divides each component magnitude by the length, one quotient bit per stage.
module v3a_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [v3a_pkg::LEN_W-1:0]  i_len,
    input  v3a_pkg::t_req              i_req,
    output logic                       o_valid,
    output v3a_pkg::t_nrm              o_nrm
);
    import v3a_pkg::*;

    typedef struct packed {
        t_req             req;
        logic [LEN_W-1:0] len;
        logic [2:0]       neg;
    } t_dctl;

    t_vec3                 n_vec;
    logic                  r_p_valid;
    t_dctl                 r_p_ctl;
    logic [DATA_WIDTH-1:0] r_p_mag [3];

    logic                  r_valid [DIV_STAGES];
    t_dctl                 r_ctl   [DIV_STAGES];
    logic [DATA_WIDTH-1:0] r_rem   [DIV_STAGES][3];
    logic [QUO_W-1:0]      r_quo   [DIV_STAGES][3];

    logic                  r_o_valid;
    t_nrm                  r_o_nrm;

    // Split components into sign and magnitude.
    assign n_vec = sel_vec(i_req);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_valid;
        end
        r_p_ctl.req <= i_req;
        r_p_ctl.len <= i_len;
        for (int l = 0; l < 3; l++) begin
            r_p_ctl.neg[l] <= n_vec[l][DATA_WIDTH-1];
            r_p_mag[l]     <= n_vec[l][DATA_WIDTH-1] ? -n_vec[l] : n_vec[l];
        end
    end

    // Restoring division of (magnitude << FRAC_BITS) by the length. The quotient never
    // exceeds one in fixed point, so the upper numerator bits are loaded straight in.
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
        logic                  src_valid;
        t_dctl                 src_ctl;
        logic [DATA_WIDTH-1:0] src_rem [3];
        logic [QUO_W-1:0]      src_quo [3];
        logic                  src_bit [3];
        logic [DATA_WIDTH:0]   n_trial [3];
        logic [DATA_WIDTH:0]   n_diff  [3];

        if (k == 0) begin : g_first
            always_comb begin
                src_valid = r_p_valid;
                src_ctl   = r_p_ctl;
                for (int l = 0; l < 3; l++) begin
                    src_rem[l] = r_p_mag[l] >> 1;
                    src_quo[l] = '0;
                    src_bit[l] = r_p_mag[l][0];
                end
            end
        end else begin : g_next
            always_comb begin
                src_valid = r_valid[k-1];
                src_ctl   = r_ctl[k-1];
                for (int l = 0; l < 3; l++) begin
                    src_rem[l] = r_rem[k-1][l];
                    src_quo[l] = r_quo[k-1][l];
                    src_bit[l] = 1'b0;
                end
            end
        end

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                n_trial[l] = {src_rem[l], src_bit[l]};
                n_diff[l]  = n_trial[l] - {1'b0, src_ctl.len};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= src_valid;
            end
            r_ctl[k] <= src_ctl;
            for (int l = 0; l < 3; l++) begin
                if (n_trial[l] >= {1'b0, src_ctl.len}) begin
                    r_rem[k][l] <= n_diff[l][DATA_WIDTH-1:0];
                    r_quo[k][l] <= {src_quo[l][QUO_W-2:0], 1'b1};
                end else begin
                    r_rem[k][l] <= n_trial[l][DATA_WIDTH-1:0];
                    r_quo[k][l] <= {src_quo[l][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // Restore signs. A zero length only comes from a zero vector, whose result is zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_valid[DIV_STAGES-1];
        end
        r_o_nrm.req <= r_ctl[DIV_STAGES-1].req;
        r_o_nrm.len <= r_ctl[DIV_STAGES-1].len;
        for (int l = 0; l < 3; l++) begin
            if (r_ctl[DIV_STAGES-1].len == '0) begin
                r_o_nrm.nb[l] <= '0;
            end else if (r_ctl[DIV_STAGES-1].neg[l]) begin
                r_o_nrm.nb[l] <= -NRM_W'(r_quo[DIV_STAGES-1][l]);
            end else begin
                r_o_nrm.nb[l] <= NRM_W'(r_quo[DIV_STAGES-1][l]);
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_nrm   = r_o_nrm;

endmodule

/* rtl/v3a_arith.sv */
// Multiply, accumulate, projection and saturation stages of the vector ALU.
module v3a_arith (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  v3a_pkg::t_nrm  i_nrm,
    output logic           o_valid,
    output v3a_pkg::t_res  o_res
);
    import v3a_pkg::*;

    t_req                       rq;
    t_data                      n_va [3];
    t_data                      n_vb [3];
    t_data                      n_x  [3];
    t_data                      n_y  [3];

    logic                       r1_valid;
    t_cmd                       r1_cmd;
    logic [LEN_W-1:0]           r1_len;
    logic [2:0][NRM_W-1:0]      r1_nb;
    logic signed [PROD_W-1:0]   r1_p  [6];
    logic signed [DATA_WIDTH:0] r1_as [3];

    logic signed [WIDE_W-1:0]   n_p   [6];
    logic signed [WIDE_W-1:0]   n_sum;
    logic signed [WIDE_W-1:0]   n_sh;
    logic signed [WIDE_W-1:0]   n_v   [3];
    logic signed [WIDE_W-1:0]   n_s;

    logic                       r2_valid;
    t_cmd                       r2_cmd;
    logic signed [WIDE_W-1:0]   r2_v  [3];
    logic signed [WIDE_W-1:0]   r2_s;
    logic signed [DOT_W-1:0]    r2_d;
    logic [2:0][NRM_W-1:0]      r2_nb;

    logic                       r3_valid;
    t_cmd                       r3_cmd;
    logic signed [WIDE_W-1:0]   r3_v  [3];
    logic signed [WIDE_W-1:0]   r3_s;
    logic signed [PRJ_W-1:0]    r3_pr [3];

    logic signed [PRJ_W-1:0]    n_prs [3];
    logic signed [WIDE_W-1:0]   n_fv  [3];
    t_res                       n_res;

    logic                       r4_valid;
    t_res                       r4_res;

    assign rq = i_nrm.req;

    // Operand selection for the six multipliers.
    always_comb begin
        n_va[0] = rq.a_x;
        n_va[1] = rq.a_y;
        n_va[2] = rq.a_z;
        n_vb[0] = rq.b_x;
        n_vb[1] = rq.b_y;
        n_vb[2] = rq.b_z;
        for (int l = 0; l < 3; l++) begin
            n_x[l] = (rq.cmd == CMD_CROSS) ? n_va[(l + 1) % 3] : n_va[l];
        end
        case (rq.cmd)
            CMD_SCALE: begin
                for (int l = 0; l < 3; l++) n_y[l] = rq.factor;
            end
            CMD_CROSS: begin
                for (int l = 0; l < 3; l++) n_y[l] = n_vb[(l + 2) % 3];
            end
            CMD_PROJ: begin
                for (int l = 0; l < 3; l++) n_y[l] = DATA_WIDTH'($signed(i_nrm.nb[l]));
            end
            default: begin
                for (int l = 0; l < 3; l++) n_y[l] = n_vb[l];
            end
        endcase
    end

    // Stage 1: products, plus the component-wise sum or difference.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        r1_cmd <= rq.cmd;
        r1_len <= i_nrm.len;
        r1_nb  <= i_nrm.nb;
        for (int l = 0; l < 3; l++) begin
            r1_p[l]     <= PROD_W'(n_x[l]) * PROD_W'(n_y[l]);
            r1_p[l + 3] <= PROD_W'(n_vb[(l + 1) % 3]) * PROD_W'(n_va[(l + 2) % 3]);
            r1_as[l]    <= (rq.cmd == CMD_SUB) ?
                           (DATA_WIDTH+1)'(n_va[l]) - (DATA_WIDTH+1)'(n_vb[l]) :
                           (DATA_WIDTH+1)'(n_va[l]) + (DATA_WIDTH+1)'(n_vb[l]);
        end
    end

    // Stage 2: product sums and differences with the fraction bits dropped toward minus infinity; result selection.
    always_comb begin
        for (int l = 0; l < 6; l++) n_p[l] = WIDE_W'(r1_p[l]);
        n_sum = n_p[0] + n_p[1] + n_p[2];
        n_sh  = n_sum >>> FRAC_BITS;
        for (int l = 0; l < 3; l++) begin
            case (r1_cmd)
                CMD_SCALE: n_v[l] = n_p[l] >>> FRAC_BITS;
                CMD_NORM:  n_v[l] = WIDE_W'($signed(r1_nb[l]));
                CMD_ADD:   n_v[l] = WIDE_W'(r1_as[l]);
                CMD_SUB:   n_v[l] = WIDE_W'(r1_as[l]);
                CMD_CROSS: n_v[l] = (n_p[l] - n_p[l + 3]) >>> FRAC_BITS;
                default:   n_v[l] = '0;
            endcase
        end
        case (r1_cmd)
            CMD_LEN: n_s = WIDE_W'(r1_len);
            CMD_DOT: n_s = n_sh;
            default: n_s = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_cmd <= r1_cmd;
        r2_v   <= n_v;
        r2_s   <= n_s;
        r2_d   <= n_sh[DOT_W-1:0];
        r2_nb  <= r1_nb;
    end

    // Stage 3: scale the normalized vector by the dot product for projection.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_cmd <= r2_cmd;
        r3_v   <= r2_v;
        r3_s   <= r2_s;
        for (int l = 0; l < 3; l++) begin
            r3_pr[l] <= PRJ_W'($signed(r2_nb[l])) * PRJ_W'(r2_d);
        end
    end

    // Stage 4: final shift, saturation and the overflow flag.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_prs[l] = r3_pr[l] >>> FRAC_BITS;
            // The shifted projection is sign-extended to the wide range.
            n_fv[l]  = (r3_cmd == CMD_PROJ) ? WIDE_W'(n_prs[l]) : r3_v[l];
        end
        n_res.res_x      = sat_val(n_fv[0]);
        n_res.res_y      = sat_val(n_fv[1]);
        n_res.res_z      = sat_val(n_fv[2]);
        n_res.res_scalar = sat_val(r3_s);
        n_res.overflow   = sat_ovf(n_fv[0]) | sat_ovf(n_fv[1]) | sat_ovf(n_fv[2])
                         | sat_ovf(r3_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
        r4_res <= n_res;
    end

    assign o_valid = r4_valid;
    assign o_res   = r4_res;

endmodule

/* rtl/vector3_alu.sv */
// Path: every accepted request passes the input, square and sum registers, the 32 square-root
// stages, the divider prep, the 17 quotient stages, the sign register and the ALU stages.
// Throughput: one request per cycle; o_busy stays low, and results leave in request order.
// Reset: synchronous, active low; it clears every stage valid bit, dropping requests in flight.
// The receiver cannot stall, so each result is shown for exactly one cycle with o_done.
// Top level of the three-component vector ALU.
module vector3_alu (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  v3a_pkg::t_req  i_req,
    output logic           o_busy,
    output logic           o_done,
    output v3a_pkg::t_res  o_res
);
    import v3a_pkg::*;

    logic              r_in_valid;
    t_req              r_in_req;
    t_vec3             n_vec;
    logic signed [PROD_W-1:0] n_sq [3];

    logic              r_sq_valid;
    t_req              r_sq_req;
    logic [PROD_W-1:0] r_sq [3];

    logic              r_sm_valid;
    t_req              r_sm_req;
    logic [PROD_W-1:0] r_sum;

    logic              rt_valid;
    logic [LEN_W-1:0]  rt_len;
    t_req              rt_req;

    logic              dv_valid;
    t_nrm              dv_nrm;

    // The pipeline takes a request every cycle.
    assign o_busy = 1'b0;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start & ~o_busy;
        end
        r_in_req <= i_req;
    end

    // Squares of the vector whose length is needed.
    assign n_vec = sel_vec(r_in_req);

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_sq[l] = PROD_W'($signed(n_vec[l])) * PROD_W'($signed(n_vec[l]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid <= 1'b0;
        end else begin
            r_sq_valid <= r_in_valid;
        end
        r_sq_req <= r_in_req;
        for (int l = 0; l < 3; l++) begin
            r_sq[l] <= n_sq[l];
        end
    end

    // Sum of squares; three values of at most 2^62 each fit the product width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm_valid <= 1'b0;
        end else begin
            r_sm_valid <= r_sq_valid;
        end
        r_sm_req <= r_sq_req;
        r_sum    <= r_sq[0] + r_sq[1] + r_sq[2];
    end

    v3a_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_sm_valid),
        .i_sum   (r_sum),
        .i_req   (r_sm_req),
        .o_valid (rt_valid),
        .o_len   (rt_len),
        .o_req   (rt_req)
    );

    v3a_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rt_valid),
        .i_len   (rt_len),
        .i_req   (rt_req),
        .o_valid (dv_valid),
        .o_nrm   (dv_nrm)
    );

    v3a_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dv_valid),
        .i_nrm   (dv_nrm),
        .o_valid (o_done),
        .o_res   (o_res)
    );

endmodule

/* rtl/v3a_check.sv */
// Port-level assertions for the vector ALU and the bind that attaches them.
module v3a_check (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_start,
    input v3a_pkg::t_req  i_req,
    input logic           o_busy,
    input logic           o_done,
    input v3a_pkg::t_res  o_res
);
    import v3a_pkg::*;

    // Every accepted request produces a result after the fixed latency.
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_done)
        else $error("accepted request produced no result");

    // No result appears without a request accepted the latency earlier.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, LATENCY))
        else $error("result without a matching request");

    // The overflow flag implies some field sits at a saturation limit.
    a_ovf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.overflow) |->
            (o_res.res_x == DATA_MAX || o_res.res_x == DATA_MIN ||
             o_res.res_y == DATA_MAX || o_res.res_y == DATA_MIN ||
             o_res.res_z == DATA_MAX || o_res.res_z == DATA_MIN ||
             o_res.res_scalar == DATA_MAX || o_res.res_scalar == DATA_MIN))
        else $error("overflow set with no saturated field");

    // A length request gives a zero vector and a non-negative scalar.
    a_len_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_start && !o_busy && i_req.cmd == CMD_LEN, LATENCY)) |->
            (o_res.res_x == '0 && o_res.res_y == '0 && o_res.res_z == '0 &&
             !o_res.res_scalar[DATA_WIDTH-1]))
        else $error("length result has bad fields");

endmodule

bind vector3_alu v3a_check u_v3a_check (.*);

/* dv/tb_vector3_alu.sv */
// Self-checking testbench for the three-component vector ALU.
module tb_vector3_alu;
    import v3a_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int DRAIN_CYCLES    = 80;
    localparam int RANDOM_ITEMS    = 730;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_start;
    t_req  i_req;
    logic  o_busy;
    logic  o_done;
    t_res  o_res;

    t_res  exp_results[$];
    int    n_errors;
    int    n_sent;
    int    n_checked;
    int    n_ovf;
    int    idle_cycles;
    int    cmd_count[8];

    vector3_alu u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_req  (i_req),
        .o_busy (o_busy),
        .o_done (o_done),
        .o_res  (o_res)
    );

    // Clock with an 8 ns period, starting low so the first rising edge is at 4 ns.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Clamp a wide value to 32 bits and note whether it was clamped.
    function automatic t_data clamp(input logic signed [127:0] v, inout logic hit);
        if (v > 128'sd2147483647) begin
            hit = 1'b1;
            return DATA_MAX;
        end
        if (v < -128'sd2147483648) begin
            hit = 1'b1;
            return DATA_MIN;
        end
        return v[31:0];
    endfunction

    // Integer square root, floor, of a nonnegative value.
    function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
        logic [127:0] r;
        logic [127:0] bitv;
        r = 0;
        bitv = 128'd1 << 126;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [127:0] vec_length(input logic signed [127:0] v[3]);
        return $signed(floor_sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]));
    endfunction

    // Unit vector in Q16.16, quotients truncated toward zero; zero length passes through.
    function automatic void unit_vec(input logic signed [127:0] v[3],
                                     output logic signed [127:0] o[3]);
        logic signed [127:0] l;
        logic signed [127:0] m;
        l = vec_length(v);
        for (int i = 0; i < 3; i++) begin
            if (l == 0) begin
                o[i] = v[i];
            end else begin
                m = ((v[i] < 0) ? -v[i] : v[i]) <<< FRAC_BITS;
                o[i] = (v[i] < 0) ? -(m / l) : (m / l);
            end
        end
    endfunction

    // Arithmetic shift floors toward minus infinity.
    function automatic logic signed [127:0] drop_frac(input logic signed [127:0] p);
        return p >>> FRAC_BITS;
    endfunction

    // Expected result of one request.
    function automatic t_res vector_result(input t_req r);
        logic signed [127:0] a[3];
        logic signed [127:0] b[3];
        logic signed [127:0] v[3];
        logic signed [127:0] nb[3];
        logic signed [127:0] f;
        logic signed [127:0] d;
        logic hit;
        t_res res;
        a[0] = r.a_x; a[1] = r.a_y; a[2] = r.a_z;
        b[0] = r.b_x; b[1] = r.b_y; b[2] = r.b_z;
        f = r.factor;
        hit = 1'b0;
        res = '0;
        for (int i = 0; i < 3; i++) v[i] = 0;
        case (r.cmd)
            CMD_LEN:   res.res_scalar = clamp(vec_length(a), hit);
            CMD_SCALE: for (int i = 0; i < 3; i++) v[i] = drop_frac(a[i] * f);
            CMD_NORM:  unit_vec(a, v);
            CMD_ADD:   for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
            CMD_SUB:   for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
            CMD_DOT: begin
                res.res_scalar = clamp(drop_frac(a[0]*b[0] + a[1]*b[1] + a[2]*b[2]), hit);
            end
            CMD_CROSS: begin
                v[0] = drop_frac(a[1] * b[2] - b[1] * a[2]);
                v[1] = drop_frac(a[2] * b[0] - b[2] * a[0]);
                v[2] = drop_frac(a[0] * b[1] - b[0] * a[1]);
            end
            default: begin
                unit_vec(b, nb);
                d = drop_frac(a[0] * nb[0] + a[1] * nb[1] + a[2] * nb[2]);
                for (int i = 0; i < 3; i++) v[i] = drop_frac(nb[i] * d);
            end
        endcase
        if (r.cmd != CMD_LEN && r.cmd != CMD_DOT) begin
            res.res_x = clamp(v[0], hit);
            res.res_y = clamp(v[1], hit);
            res.res_z = clamp(v[2], hit);
        end
        res.overflow = hit;
        return res;
    endfunction

    // Drive one request, after a random gap when allowed, and wait until it is taken.
    task automatic send_request(input t_req r, input bit allow_gap = 1'b1);
        int gap;
        gap = allow_gap ? $urandom_range(0, 16) : 0;
        if (allow_gap && $urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        exp_results.push_back(vector_result(r));
        cmd_count[r.cmd]++;
        n_sent++;
    endtask

    function automatic t_data rand_data();
        case ($urandom_range(0, 7))
            0: return DATA_MAX;
            1: return DATA_MIN;
            2: return '0;
            3: return t_data'($signed($urandom_range(0, 8'hff)) - 128);
            4: return t_data'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
            default: return t_data'($urandom);
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req r;
        r.cmd    = t_cmd'($urandom_range(0, 7));
        r.a_x    = rand_data();
        r.a_y    = rand_data();
        r.a_z    = rand_data();
        r.b_x    = rand_data();
        r.b_y    = rand_data();
        r.b_z    = rand_data();
        r.factor = rand_data();
        // Zero vectors for normalize and projection now and then.
        if ($urandom_range(0, 15) == 0) begin
            r.a_x = '0; r.a_y = '0; r.a_z = '0;
        end
        if ($urandom_range(0, 15) == 0) begin
            r.b_x = '0; r.b_y = '0; r.b_z = '0;
        end
        return r;
    endfunction

    function automatic t_req make_req(input t_cmd c, input t_data ax, input t_data ay,
                                      input t_data az, input t_data bx, input t_data by,
                                      input t_data bz, input t_data f);
        t_req r;
        r.cmd = c;
        r.a_x = ax; r.a_y = ay; r.a_z = az;
        r.b_x = bx; r.b_y = by; r.b_z = bz;
        r.factor = f;
        return r;
    endfunction

    // Every operation at the field extremes, with zero vectors and sign boundaries.
    task automatic test_directed();
        localparam t_data ONE = 32'sh10000;
        for (int c = 0; c < 8; c++) begin
            send_request(make_req(t_cmd'(c), DATA_MAX, DATA_MAX, DATA_MAX,
                                  DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX));
            send_request(make_req(t_cmd'(c), DATA_MIN, DATA_MIN, DATA_MIN,
                                  DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN));
        end
        send_request(make_req(CMD_NORM, '0, '0, '0, ONE, ONE, ONE, ONE));
        send_request(make_req(CMD_PROJ, ONE, -ONE, ONE, '0, '0, '0, '0));
        send_request(make_req(CMD_NORM, -32'sd3, 32'sd4, '0, '0, '0, '0, '0));
        send_request(make_req(CMD_SCALE, -32'sd1, 32'sd1, ONE, '0, '0, '0, -32'sd1));
        send_request(make_req(CMD_LEN, '0, '0, '0, '0, '0, '0, '0));
        send_request(make_req(CMD_DOT, -32'sd1, 32'sd0, 32'sd0, 32'sd1, 0, 0, 0));
        send_request(make_req(CMD_CROSS, ONE, '0, '0, '0, ONE, '0, '0));
        send_request(make_req(CMD_ADD, 32'sd1, -32'sd1, DATA_MAX, -32'sd1, 32'sd1, 32'sd1, 0));
    endtask

    // Random requests back to back and with random gaps.
    task automatic test_random();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            send_request(rand_req(), (i % 100) >= 30);
        end
    endtask

    // Compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_done) begin
            if (exp_results.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, o_res);
                n_errors++;
            end else begin
                want = exp_results.pop_front();
                n_checked++;
                if (want.overflow) n_ovf++;
                if (o_res.res_x !== want.res_x) begin
                    $display("%0t: res_x expected %h got %h", $realtime, want.res_x, o_res.res_x);
                    n_errors++;
                end
                if (o_res.res_y !== want.res_y) begin
                    $display("%0t: res_y expected %h got %h", $realtime, want.res_y, o_res.res_y);
                    n_errors++;
                end
                if (o_res.res_z !== want.res_z) begin
                    $display("%0t: res_z expected %h got %h", $realtime, want.res_z, o_res.res_z);
                    n_errors++;
                end
                if (o_res.res_scalar !== want.res_scalar) begin
                    $display("%0t: res_scalar expected %h got %h", $realtime,
                             want.res_scalar, o_res.res_scalar);
                    n_errors++;
                end
                if (o_res.overflow !== want.overflow) begin
                    $display("%0t: overflow expected %b got %b", $realtime,
                             want.overflow, o_res.overflow);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which no request or result moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (i_start && !o_busy)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: watchdog expired", $realtime);
            $display("** vector3_alu: FAILED **");
            $finish;
        end
    end

    initial begin
        int tail;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_req       = '0;
        n_errors    = 0;
        n_sent      = 0;
        n_checked   = 0;
        n_ovf       = 0;
        idle_cycles = 0;
        for (int i = 0; i < 8; i++) cmd_count[i] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random();
        i_start <= 1'b0;

        while (exp_results.size() != 0) @(posedge i_clk);
        tail = 0;
        while (tail < DRAIN_CYCLES) begin
            @(posedge i_clk);
            tail++;
        end

        $display("Sent %0d requests, checked %0d results, %0d with saturation.",
                 n_sent, n_checked, n_ovf);
        $display("Per operation: len %0d scale %0d norm %0d add %0d sub %0d dot %0d cross %0d proj %0d",
                 cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3],
                 cmd_count[4], cmd_count[5], cmd_count[6], cmd_count[7]);
        if (n_errors == 0 && exp_results.size() == 0) begin
            $display("** vector3_alu: PASSED **");
        end else begin
            $display("** vector3_alu: FAILED **");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/v3a_pkg.sv
rtl/v3a_sqrt.sv
rtl/v3a_div.sv
rtl/v3a_arith.sv
rtl/vector3_alu.sv
rtl/v3a_check.sv
dv/tb_vector3_alu.sv
